@@ sv/per_client_token_bucket_limiter_macros.svh @@
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_MACROS_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define PCTBL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define PCTBL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pctbl_pkg.sv @@
package pctbl_pkg;

  localparam int CLIENT_ID_W = 10;
  localparam int TIME_W      = 48;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int NUM_CLIENTS_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_AMOUNT   = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] CAPACITY_RST = 16'd10;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd1000;
  localparam logic [CFG_W-1:0] AMOUNT_RST   = 16'd1;

  // divider operand selection
  typedef enum logic {
    DIV_ELAPSED = 1'b0,
    DIV_FRAC    = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     clear;
    logic     accept;
    logic     slot_rem;
    logic     rd;
    logic     look;
    logic     div_start;
    div_sel_t div_sel;
    logic     save_q;
    logic     mul_whole;
    logic     decide;
    logic     add_whole;
    logic     add_frac;
    logic     clamp;
    logic     take;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_busy;
    logic used;
    logic q_zero;
    logic over;
    logic out_full;
  } dp_sts_t;

endpackage

@@ sv/pctbl_if.sv @@
interface pctbl_req_if;
  logic                               valid;
  logic                               ready;
  logic [pctbl_pkg::CLIENT_ID_W-1:0]  client_id;
  logic [pctbl_pkg::TIME_W-1:0]       now_ms;

  modport source(output valid, client_id, now_ms, input ready);
  modport sink(input valid, client_id, now_ms, output ready);
endinterface

interface pctbl_rsp_if;
  logic valid;
  logic ready;
  logic allowed;

  modport source(output valid, allowed, input ready);
  modport sink(input valid, allowed, output ready);
endinterface

@@ sv/per_client_token_bucket_limiter.sv @@
// channel  dir  handshake        payload
// req      in   valid / ready    client_id[9:0], now_ms[47:0]
// rsp      out  valid / ready    allowed
// cfg      in   cfg_we           cfg_index[1:0], cfg_wdata[15:0]
//
// after reset a clearing pass marks every bucket unused; no item is taken during it
// first touch of a bucket skips the divider; less than one interval elapsed: one division;
// refill: two divisions by the one-bit-per-cycle divider (one when the whole gain exceeds capacity)
// the S_MOD state is added when NUM_CLIENTS is below 1024 (client index reduced by a reciprocal multiply)
// one item at a time; the next item is taken while the result waits in the output register
// a stalled result blocks only the final table write of the following item
module per_client_token_bucket_limiter #(
  parameter int NUM_CLIENTS   = pctbl_pkg::NUM_CLIENTS_DEF,
  parameter int FRACTION_BITS = pctbl_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pctbl_req_if.sink                       req,
  pctbl_rsp_if.source                     rsp,
  input  logic                            cfg_we,
  input  logic [pctbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pctbl_pkg::CFG_W-1:0]     cfg_wdata
);

  pctbl_pkg::ctrl_cmd_t cmd;
  pctbl_pkg::dp_sts_t   sts;

  pctbl_ctrl #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pctbl_dp #(
    .NUM_CLIENTS   (NUM_CLIENTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .req_client_id (req.client_id),
    .req_now_ms    (req.now_ms),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .rsp_allowed   (rsp.allowed)
  );

endmodule

@@ sv/pctbl_ram.sv @@
module pctbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pctbl_div.sv @@
`include "per_client_token_bucket_limiter_macros.svh"

module pctbl_div #(
  parameter int DVD_W = pctbl_pkg::TIME_W,
  parameter int DSR_W = pctbl_pkg::CFG_W,
  localparam int CNT_W = $clog2(DVD_W + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  input  logic [CNT_W-1:0] steps,
  output logic             busy,
  output logic [DVD_W-1:0] quotient,
  output logic [DSR_W-1:0] remainder
);

  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle; dividend is left aligned
  assign trial = {rem, quo[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= steps;
    end else if (busy) begin
      rem <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `PCTBL_ASSERT_SAME(a_rem_range, clk, rst, !busy && $past(busy), rem < dsr, "remainder not below divisor")

endmodule

@@ sv/pctbl_dp.sv @@
`include "per_client_token_bucket_limiter_macros.svh"

module pctbl_dp #(
  parameter int NUM_CLIENTS   = pctbl_pkg::NUM_CLIENTS_DEF,
  parameter int FRACTION_BITS = pctbl_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pctbl_pkg::ctrl_cmd_t                cmd,
  output pctbl_pkg::dp_sts_t                  sts,
  input  logic                                cfg_we,
  input  logic [pctbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pctbl_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [pctbl_pkg::CLIENT_ID_W-1:0]   req_client_id,
  input  logic [pctbl_pkg::TIME_W-1:0]        req_now_ms,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic                                rsp_allowed
);

  localparam int CFG_W  = pctbl_pkg::CFG_W;
  localparam int TIME_W = pctbl_pkg::TIME_W;
  localparam int ID_W   = pctbl_pkg::CLIENT_ID_W;
  localparam int SLOT_W = $clog2(NUM_CLIENTS);
  localparam int LVL_W  = CFG_W + FRACTION_BITS;
  localparam int SUM_W  = LVL_W + 2;
  localparam int PROD_W = 2 * CFG_W;
  localparam int DVD_W  = (TIME_W > PROD_W + FRACTION_BITS) ? TIME_W : PROD_W + FRACTION_BITS;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int ENT_W  = 1 + LVL_W + TIME_W;

  // client index modulo table size by reciprocal multiply, exact for every index
  localparam int RCP_SH = ID_W + SLOT_W;
  localparam int RCP_W  = RCP_SH + 1;
  localparam int RPRD_W = ID_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + 64'(NUM_CLIENTS) - 64'd1) / 64'(NUM_CLIENTS));

  logic [CFG_W-1:0]  capacity;
  logic [CFG_W-1:0]  interval;
  logic [CFG_W-1:0]  amount;
  logic [CFG_W-1:0]  ivl;
  logic [LVL_W-1:0]  full;
  logic [LVL_W-1:0]  one_tok;

  logic [TIME_W-1:0] now_reg;
  logic [SLOT_W-1:0] slot;
  logic [LVL_W-1:0]  level;
  logic [TIME_W-1:0] last;
  logic [TIME_W-1:0] q_reg;
  logic [CFG_W-1:0]  rem_reg;
  logic [PROD_W-1:0] prod;
  logic              over_q;
  logic [CFG_W-1:0]  whole;
  logic [SUM_W-1:0]  sum;
  logic              allowed_reg;
  logic [SLOT_W-1:0] clr_addr;

  logic [ID_W-1:0]   id_reg;
  logic [ID_W-1:0]   id_quo;
  logic [RPRD_W-1:0] rcp_p;
  logic [ID_W-1:0]   id_rem;

  logic [ENT_W-1:0]  rdata;
  logic              rd_used;
  logic [LVL_W-1:0]  rd_level;
  logic [TIME_W-1:0] rd_last;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;

  logic [TIME_W-1:0] elapsed;
  logic [DVD_W-1:0]  dvd;
  logic [CFG_W-1:0]  dsr;
  logic [CNT_W-1:0]  steps;
  logic              div_busy;
  logic [DVD_W-1:0]  div_quo;
  logic [CFG_W-1:0]  div_rem;

  logic [CFG_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic              over;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= pctbl_pkg::CAPACITY_RST;
      interval <= pctbl_pkg::INTERVAL_RST;
      amount   <= pctbl_pkg::AMOUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pctbl_pkg::REG_CAPACITY: capacity <= cfg_wdata;
        pctbl_pkg::REG_INTERVAL: interval <= cfg_wdata;
        pctbl_pkg::REG_AMOUNT:   amount   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ivl     = (interval == '0) ? CFG_W'(1) : interval;
  assign full    = LVL_W'(capacity) << FRACTION_BITS;
  assign one_tok = LVL_W'(1) << FRACTION_BITS;

  // bucket table: {in use, level, last refill time}
  assign rd_used  = rdata[ENT_W-1];
  assign rd_level = rdata[ENT_W-2 -: LVL_W];
  assign rd_last  = rdata[TIME_W-1:0];

  assign ram_we    = cmd.clear | cmd.commit;
  assign ram_waddr = cmd.clear ? clr_addr : slot;
  assign ram_wdata = cmd.clear ? '0 : {1'b1, level, last};

  pctbl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CLIENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (slot),
    .rdata (rdata)
  );

  assign elapsed = now_reg - rd_last;

  assign rcp_p  = RPRD_W'(req_client_id) * RPRD_W'(RCP_MUL);
  assign id_rem = id_reg - ID_W'(id_quo * ID_W'(NUM_CLIENTS));

  always_comb begin
    dvd   = DVD_W'(elapsed) << (DVD_W - TIME_W);
    dsr   = ivl;
    steps = CNT_W'(TIME_W);
    case (cmd.div_sel)
      pctbl_pkg::DIV_ELAPSED: begin
        dvd   = DVD_W'(elapsed) << (DVD_W - TIME_W);
        dsr   = ivl;
        steps = CNT_W'(TIME_W);
      end
      pctbl_pkg::DIV_FRAC: begin
        // (rem * amount) << FRACTION_BITS, left aligned
        dvd   = DVD_W'(prod) << (DVD_W - PROD_W);
        dsr   = ivl;
        steps = CNT_W'(PROD_W + FRACTION_BITS);
      end
      default: ;
    endcase
  end

  pctbl_div #(
    .DVD_W (DVD_W),
    .DSR_W (CFG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .steps     (steps),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign mul_a = cmd.decide ? rem_reg : q_reg[CFG_W-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(amount);
  assign over  = over_q || (prod > PROD_W'(capacity));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_reg <= req_now_ms;
      slot    <= SLOT_W'(req_client_id);
      id_reg  <= req_client_id;
      id_quo  <= ID_W'(rcp_p >> RCP_SH);
    end
    if (cmd.slot_rem) begin
      slot <= SLOT_W'(id_rem);
    end
    if (cmd.look) begin
      // first touch starts full
      if (rd_used) begin
        level <= rd_level;
        last  <= rd_last;
      end else begin
        level <= full;
        last  <= now_reg;
      end
    end
    if (cmd.save_q) begin
      q_reg   <= div_quo[TIME_W-1:0];
      rem_reg <= div_rem;
    end
    if (cmd.mul_whole) begin
      prod   <= mul_p;
      over_q <= (q_reg[TIME_W-1:CFG_W] != '0) && (amount != '0);
    end
    if (cmd.decide) begin
      if (over) begin
        level <= full;
        last  <= now_reg;
      end
      whole <= prod[CFG_W-1:0];
      prod  <= mul_p;
    end
    if (cmd.add_whole) begin
      sum <= SUM_W'(level) + (SUM_W'(whole) << FRACTION_BITS);
    end
    if (cmd.add_frac) begin
      sum <= sum + SUM_W'(div_quo[LVL_W-1:0]);
    end
    if (cmd.clamp) begin
      level <= (sum > SUM_W'(full)) ? full : sum[LVL_W-1:0];
      last  <= now_reg;
    end
    if (cmd.take) begin
      if (level >= one_tok) begin
        level       <= level - one_tok;
        allowed_reg <= 1'b1;
      end else begin
        allowed_reg <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_allowed <= allowed_reg;
    end
  end

  always_comb begin
    sts          = '0;
    sts.clr_last = clr_addr == SLOT_W'(NUM_CLIENTS - 1);
    sts.div_busy = div_busy;
    sts.used     = rd_used;
    sts.q_zero   = q_reg == '0;
    sts.over     = over;
    sts.out_full = rsp_valid && !rsp_ready;
  end

  `PCTBL_ASSERT_NEXT(a_clamp_cap, clk, rst, cmd.clamp, level <= full, "level above capacity after refill")

endmodule

@@ sv/pctbl_ctrl.sv @@
`include "per_client_token_bucket_limiter_macros.svh"

module pctbl_ctrl #(
  parameter int NUM_CLIENTS = pctbl_pkg::NUM_CLIENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output pctbl_pkg::ctrl_cmd_t cmd,
  input  pctbl_pkg::dp_sts_t   sts
);

  // client index needs reducing when the table is smaller than the id range
  localparam bit NEED_MOD = NUM_CLIENTS < (2 ** pctbl_pkg::CLIENT_ID_W);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_MOD   = 13'b0000000000100,
    S_READ  = 13'b0000000001000,
    S_LOOK  = 13'b0000000010000,
    S_DIVQ  = 13'b0000000100000,
    S_MULQ  = 13'b0000001000000,
    S_MULR  = 13'b0000010000000,
    S_FGO   = 13'b0000100000000,
    S_DIVF  = 13'b0001000000000,
    S_CLAMP = 13'b0010000000000,
    S_TAKE  = 13'b0100000000000,
    S_WRITE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (NEED_MOD) begin
            state_next = S_MOD;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_MOD: begin
        cmd.slot_rem = 1'b1;
        state_next   = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (sts.used) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = pctbl_pkg::DIV_ELAPSED;
          state_next    = S_DIVQ;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_DIVQ: begin
        if (!sts.div_busy) begin
          cmd.save_q = 1'b1;
          state_next = S_MULQ;
        end
      end
      S_MULQ: begin
        // less than one interval since the last refill
        if (sts.q_zero) begin
          state_next = S_TAKE;
        end else begin
          cmd.mul_whole = 1'b1;
          state_next    = S_MULR;
        end
      end
      S_MULR: begin
        cmd.decide = 1'b1;
        state_next = sts.over ? S_TAKE : S_FGO;
      end
      S_FGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pctbl_pkg::DIV_FRAC;
        cmd.add_whole = 1'b1;
        state_next    = S_DIVF;
      end
      S_DIVF: begin
        if (!sts.div_busy) begin
          cmd.add_frac = 1'b1;
          state_next   = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `PCTBL_ASSERT_SAME(a_div_free, clk, rst, cmd.div_start, !sts.div_busy, "divider started while busy")
  `PCTBL_ASSERT_SAME(a_out_free, clk, rst, cmd.commit, !sts.out_full, "result written over a waiting item")
  `PCTBL_ASSERT_SAME(a_div_wait, clk, rst, sts.div_busy, state == S_DIVQ || state == S_DIVF, "divider busy outside a wait state")

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  import pctbl_pkg::*;

  localparam int TABLE_SIZE    = NUM_CLIENTS_DEF;
  localparam int FRAC_W        = FRACTION_BITS_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 830;
  localparam int LONG_HOLD     = 600;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [TIME_W-1:0]    TIME_MAX  = '1;
  localparam logic [TIME_W-1:0]    T_LATE    = TIME_MAX - 48'd999;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  pctbl_req_if req_ch();
  pctbl_rsp_if rsp_ch();

  per_client_token_bucket_limiter u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of registers and bucket table
  bit [63:0]       cap_sh;
  bit [63:0]       ivl_sh;
  bit [63:0]       amt_sh;
  bit              bucket_used [TABLE_SIZE];
  bit [63:0]       bucket_fill [TABLE_SIZE];
  bit [TIME_W-1:0] bucket_stamp [TABLE_SIZE];

  bit allow_pending[$];
  bit want_allow;

  int errors     = 0;
  int n_req      = 0;
  int n_allowed  = 0;
  int n_denied   = 0;
  int n_settings = 0;

  int burst_left   = 0;
  bit sender_eager = 0;
  int hold_request = 0;
  int hold_left    = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_period    = 2;
  int rx_stall     = 1;
  int rx_count     = 0;

  logic [TIME_W-1:0] time_cursor;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("** per_client_token_bucket_limiter: FAILED **");
    $finish;
  end

  function automatic bit bucket_decision(input logic [CLIENT_ID_W-1:0] cid,
                                         input logic [TIME_W-1:0] now);
    int unsigned     s;
    bit [TIME_W-1:0] gap48;
    bit [63:0]       elapsed, ivl, full, whole, frac, lvl, one;
    s   = int'(cid) % TABLE_SIZE;
    one = 64'd1 << FRAC_W;
    if (!bucket_used[s]) begin
      bucket_used[s]  = 1'b1;
      bucket_fill[s]  = cap_sh << FRAC_W;
      bucket_stamp[s] = now;
    end
    gap48   = now - bucket_stamp[s];
    elapsed = 64'(gap48);
    ivl     = (ivl_sh == 0) ? 64'd1 : ivl_sh;
    full    = cap_sh << FRAC_W;
    if (elapsed >= ivl) begin
      whole = (elapsed / ivl) * amt_sh;
      if (whole > cap_sh) begin
        lvl = full;
      end else begin
        frac = (((elapsed % ivl) * amt_sh) << FRAC_W) / ivl;
        lvl  = bucket_fill[s] + (whole << FRAC_W) + frac;
        if (lvl > full) lvl = full;
      end
      bucket_fill[s]  = lvl;
      bucket_stamp[s] = now;
    end
    if (bucket_fill[s] >= one) begin
      bucket_fill[s] -= one;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_CAPACITY: cap_sh = 64'(val);
      REG_INTERVAL: ivl_sh = 64'(val);
      REG_AMOUNT:   amt_sh = 64'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering, wait for every result, then let the last table write finish
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    burst_left   = 0;
    while (allow_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] ivl,
                            input logic [CFG_W-1:0] amt);
    drain();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_INTERVAL, ivl);
    write_reg(REG_AMOUNT, amt);
    n_settings++;
  endtask

  task automatic send_req(input logic [CLIENT_ID_W-1:0] cid, input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = sender_eager ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.client_id = cid;
    req_ch.now_ms    = now;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    allow_pending.push_back(bucket_decision(cid, now));
    n_req++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (allow_pending.size() == 0) begin
        errors++;
        $error("allowed: no request pending, got %0b", rsp_ch.allowed);
      end else begin
        want_allow = allow_pending.pop_front();
        if (rsp_ch.allowed !== want_allow) begin
          errors++;
          $error("allowed: expected %0b, got %0b", want_allow, rsp_ch.allowed);
        end
        if (want_allow) n_allowed++;
        else n_denied++;
      end
    end
  end

  // result side: long hold on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(20, 80);
        rx_mode      = $urandom_range(0, 2);
        rx_period    = $urandom_range(2, 9);
        rx_stall     = $urandom_range(1, rx_period - 1);
      end
      rx_mode_left--;
      rx_count++;
      case (rx_mode)
        0:       rsp_ch.ready = 1'b1;
        1:       rsp_ch.ready = (rx_count % rx_period) >= rx_stall;
        default: rsp_ch.ready = ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // registers at reset values, time wrapping past the top of the range
  task automatic test_reset_values();
    send_req(10'd1023, T_LATE);
    send_req(10'd1023, TIME_MAX);
    send_req(10'd1023, T_LATE + 48'd1999);
    send_req(10'd0, 48'd0);
  endtask

  task automatic test_fraction_refill();
    set_config(16'd2, 16'd10, 16'd1);
    send_req(10'd11, 48'd1000);
    send_req(10'd11, 48'd1000);
    send_req(10'd11, 48'd1005);
    send_req(10'd11, 48'd1015);
    send_req(10'd11, 48'd1020);
    send_req(10'd11, 48'd1025);
  endtask

  task automatic test_special_registers();
    set_config(16'd0, 16'd1000, 16'd1);
    send_req(10'd7, 48'd100);
    // zero interval behaves as one
    set_config(16'd65535, 16'd0, 16'd65535);
    write_reg(REG_SPARE, 16'hFFFF);
    send_req(10'd7, 48'd101);
    drain();
    write_reg(REG_AMOUNT, 16'd0);
    send_req(10'd7, 48'd500);
    // gain far above capacity, then time running backwards
    set_config(16'd5, 16'd3, 16'd65535);
    send_req(10'd7, 48'd600);
    send_req(10'd7, 48'd550);
    drain();
    write_reg(REG_CAPACITY, 16'd1000);
    send_req(10'd9, 48'd0);
    // level stays above a lowered capacity until the next refill
    set_config(16'd1, 16'd65535, 16'd0);
    send_req(10'd9, 48'd10);
    send_req(10'd9, 48'd65545);
    send_req(10'd9, 48'd65546);
  endtask

  task automatic test_backpressure();
    int k;
    drain();
    sender_eager = 1'b1;
    hold_request = LONG_HOLD;
    for (k = 0; k < 10; k++) begin
      send_req(CLIENT_ID_W'($urandom), time_cursor);
      time_cursor += 48'd1;
    end
    drain();
  endtask

  task automatic test_random();
    int                     phase, total, len, k, pool_n, step_sel;
    logic [CLIENT_ID_W-1:0] pool [8];
    logic [CLIENT_ID_W-1:0] cid;
    logic [TIME_W-1:0]      at;
    logic [CFG_W-1:0]       c, i, a;
    int unsigned            ivl_eff;
    phase = 0;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case (phase)
        0: begin c = 16'd3;     i = 16'd10;    a = 16'd1;     end
        1: begin c = 16'd65535; i = 16'd1;     a = 16'd65535; end
        2: begin c = 16'd1;     i = 16'd65535; a = 16'd65535; end
        3: begin c = 16'd0;     i = 16'd0;     a = 16'd0;     end
        4: begin c = 16'd10;    i = 16'd0;     a = 16'd1;     end
        default: begin
          case ($urandom_range(0, 3))
            0: c = CFG_W'($urandom_range(1, 4));
            1: c = CFG_W'($urandom_range(1, 30));
            2: c = CFG_W'($urandom);
            default: c = CFG_W'($urandom_range(0, 2));
          endcase
          case ($urandom_range(0, 3))
            0: i = CFG_W'($urandom_range(1, 20));
            1: i = CFG_W'($urandom_range(20, 2000));
            2: i = CFG_W'($urandom);
            default: i = CFG_W'($urandom_range(0, 3));
          endcase
          case ($urandom_range(0, 2))
            0: a = CFG_W'($urandom_range(0, 3));
            1: a = CFG_W'($urandom_range(1, 100));
            default: a = CFG_W'($urandom);
          endcase
        end
      endcase
      set_config(c, i, a);
      sender_eager = ($urandom_range(0, 3) == 0);
      pool_n       = $urandom_range(1, 8);
      for (k = 0; k < 8; k++) pool[k] = CLIENT_ID_W'($urandom);
      ivl_eff = (i == 0) ? 1 : int'(i);
      len     = $urandom_range(60, 120);
      for (k = 0; k < len; k++) begin
        // mostly a small pool of clients revisited at interval scale, some first touches
        if ($urandom_range(0, 9) == 0) cid = CLIENT_ID_W'($urandom);
        else cid = pool[$urandom_range(0, pool_n - 1)];
        step_sel = $urandom_range(0, 99);
        if (step_sel >= 35 && step_sel < 80)
          time_cursor += TIME_W'($urandom_range(0, ivl_eff));
        else if (step_sel >= 80 && step_sel < 95)
          time_cursor += TIME_W'(ivl_eff * $urandom_range(1, 4));
        else if (step_sel >= 95 && step_sel < 98)
          time_cursor += TIME_W'({$urandom, $urandom});
        at = time_cursor;
        if (step_sel >= 98) at = time_cursor - TIME_W'($urandom_range(1, ivl_eff * 4));
        send_req(cid, at);
      end
      total += len;
      phase++;
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_CAPACITY;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.client_id = '0;
    req_ch.now_ms    = '0;
    rsp_ch.ready     = 1'b0;
    cap_sh           = 64'(CAPACITY_RST);
    ivl_sh           = 64'(INTERVAL_RST);
    amt_sh           = 64'(AMOUNT_RST);
    time_cursor      = TIME_W'({$urandom, $urandom});
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_fraction_refill();
    test_special_registers();
    test_backpressure();
    test_random();
    drain();

    $display("run covered %0d requests under %0d register settings: %0d allowed, %0d denied",
             n_req, n_settings + 1, n_allowed, n_denied);
    $display("directed corner cases, one long output stall, random client pools over wrapping time");
    if (errors == 0) begin
      $display("** per_client_token_bucket_limiter: PASSED **");
    end else begin
      $display("** per_client_token_bucket_limiter: FAILED **");
    end
    $finish;
  end

endmodule
